FILE: rtl/sobc_pkg.sv
// Shared types, constants and fixed-point helpers for the sphere/oriented-box test.
// No dependencies; every other file refers to it by scoped names.
package sobc_pkg;

    localparam int CW = 32;        // coordinate width, signed Q16.16
    localparam int QW = 16;        // quaternion / matrix entry width, Q2.14
    localparam int PW = 35;        // Q28 working width for matrix entries
    localparam int PRW = QW + CW;  // matrix entry times coordinate
    localparam int ENT_MAX = 16384;

    localparam logic signed [PW-1:0] ONE_Q28 = PW'(268435456);

    // configuration register indexes
    typedef enum logic [3:0] {
        REG_CX   = 4'd0,
        REG_CY   = 4'd1,
        REG_CZ   = 4'd2,
        REG_QW   = 4'd3,
        REG_QX   = 4'd4,
        REG_QY   = 4'd5,
        REG_QZ   = 4'd6,
        REG_EDGE = 4'd7
    } reg_idx_t;

    typedef logic signed [QW-1:0] ent_t;
    typedef ent_t [2:0][2:0]      mat_t;    // [row][col]
    typedef logic signed [CW-1:0] coord_t;
    typedef coord_t [2:0]         vec_t;
    typedef logic [CW-2:0]        ulen_t;   // unsigned Q15.16 length
    typedef logic [CW:0]          adist_t;  // magnitude of local minus clamped
    typedef logic [2*CW-3:0]      rsq_t;    // squared radius
    typedef logic signed [PRW-1:0] prod_t;

    // round a Q30-scaled value to Q16 (add half, floor shift by 14)
    function automatic logic signed [63:0] round14(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + 64'sd8192;
        return t >>> 14;
    endfunction

    // saturate to the signed coordinate range
    function automatic coord_t sat_coord(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'(coord_t'({1'b0, {(CW-1){1'b1}}}));
        lo = 64'(coord_t'({1'b1, {(CW-1){1'b0}}}));
        if (v > hi)
            return coord_t'(hi);
        else if (v < lo)
            return coord_t'(lo);
        else
            return coord_t'(v);
    endfunction

endpackage

FILE: rtl/sobc_rot.sv
// Rotation matrix builder: quaternion registers to a Q2.14 3x3 matrix in two stages.
// Depends on sobc_pkg.
module sobc_rot (
    input  logic          clk,
    input  sobc_pkg::ent_t qw,
    input  sobc_pkg::ent_t qx,
    input  sobc_pkg::ent_t qy,
    input  sobc_pkg::ent_t qz,
    output sobc_pkg::mat_t mat
);

    // products: xx yy zz xy xz yz wx wy wz
    logic signed [31:0] prod_reg  [9];
    logic signed [31:0] prod_next [9];
    sobc_pkg::mat_t     mat_reg;
    sobc_pkg::mat_t     mat_next;

    function automatic sobc_pkg::ent_t mentry(input logic signed [sobc_pkg::PW-1:0] v);
        logic signed [63:0] r;
        r = sobc_pkg::round14(64'(v));
        if (r > 64'(sobc_pkg::ENT_MAX))
            return sobc_pkg::ent_t'(sobc_pkg::ENT_MAX);
        else if (r < -64'(sobc_pkg::ENT_MAX))
            return sobc_pkg::ent_t'(-sobc_pkg::ENT_MAX);
        else
            return sobc_pkg::ent_t'(r);
    endfunction

    function automatic logic signed [sobc_pkg::PW-1:0] ext(input logic signed [31:0] p);
        return sobc_pkg::PW'(p);
    endfunction

    always_comb
    begin
        prod_next[0] = qx * qx;
        prod_next[1] = qy * qy;
        prod_next[2] = qz * qz;
        prod_next[3] = qx * qy;
        prod_next[4] = qx * qz;
        prod_next[5] = qy * qz;
        prod_next[6] = qw * qx;
        prod_next[7] = qw * qy;
        prod_next[8] = qw * qz;
    end

    always_comb
    begin
        mat_next[0][0] = mentry(sobc_pkg::ONE_Q28 - ((ext(prod_reg[1]) + ext(prod_reg[2])) <<< 1));
        mat_next[0][1] = mentry((ext(prod_reg[3]) - ext(prod_reg[8])) <<< 1);
        mat_next[0][2] = mentry((ext(prod_reg[4]) + ext(prod_reg[7])) <<< 1);
        mat_next[1][0] = mentry((ext(prod_reg[3]) + ext(prod_reg[8])) <<< 1);
        mat_next[1][1] = mentry(sobc_pkg::ONE_Q28 - ((ext(prod_reg[0]) + ext(prod_reg[2])) <<< 1));
        mat_next[1][2] = mentry((ext(prod_reg[5]) - ext(prod_reg[6])) <<< 1);
        mat_next[2][0] = mentry((ext(prod_reg[4]) - ext(prod_reg[7])) <<< 1);
        mat_next[2][1] = mentry((ext(prod_reg[5]) + ext(prod_reg[6])) <<< 1);
        mat_next[2][2] = mentry(sobc_pkg::ONE_Q28 - ((ext(prod_reg[0]) + ext(prod_reg[1])) <<< 1));
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        mat_reg  <= mat_next;
    end

    assign mat = mat_reg;

endmodule

FILE: rtl/sobc_local.sv
// Front pipeline: offset, box-frame transform, clamp to the cube (four stages).
// Depends on sobc_pkg.
module sobc_local (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sobc_pkg::vec_t    ball,
    input  sobc_pkg::ulen_t   radius,
    input  sobc_pkg::vec_t    center,
    input  sobc_pkg::mat_t    mat,
    input  sobc_pkg::ulen_t   half,
    output logic              out_valid,
    input  logic              out_ready,
    output sobc_pkg::vec_t    cl,
    output sobc_pkg::adist_t  adist [3],
    output sobc_pkg::rsq_t    rsq
);

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    sobc_pkg::vec_t   d1_reg, d1_next;
    sobc_pkg::ulen_t  rad1_reg;
    sobc_pkg::vec_t   d2_reg;
    sobc_pkg::rsq_t   rsq2_reg, rsq3_reg, rsq4_reg;
    sobc_pkg::prod_t  p3_reg [3][3];
    sobc_pkg::prod_t  p3_next [3][3];
    sobc_pkg::vec_t   cl4_reg, cl4_next;
    sobc_pkg::adist_t ad4_reg [3];
    sobc_pkg::adist_t ad4_next [3];

    // each stage moves when it is empty or the one after it moves
    assign en4      = !v4_reg || out_ready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_next[i] = sobc_pkg::sat_coord(64'(ball[i]) - 64'(center[i]));
        end
    end

    // local_i = sum_j R[j][i] * d_j
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p3_next[i][j] = mat[j][i] * d2_reg[j];
            end
        end
    end

    always_comb
    begin
        logic signed [63:0]        s;
        sobc_pkg::coord_t          loc;
        sobc_pkg::coord_t          hc;
        logic signed [sobc_pkg::CW:0] df;
        hc = sobc_pkg::coord_t'({1'b0, half});
        for (int i = 0; i < 3; i++)
        begin
            s   = 64'(p3_reg[i][0]) + 64'(p3_reg[i][1]) + 64'(p3_reg[i][2]);
            loc = sobc_pkg::sat_coord(sobc_pkg::round14(s));
            if (loc > hc)
                cl4_next[i] = hc;
            else if (loc < -hc)
                cl4_next[i] = -hc;
            else
                cl4_next[i] = loc;
            df = (sobc_pkg::CW+1)'(loc) - (sobc_pkg::CW+1)'(cl4_next[i]);
            ad4_next[i] = df[sobc_pkg::CW] ? sobc_pkg::adist_t'(-df) : sobc_pkg::adist_t'(df);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            d1_reg   <= d1_next;
            rad1_reg <= radius;
        end
        if (en2)
        begin
            d2_reg   <= d1_reg;
            rsq2_reg <= rad1_reg * rad1_reg;
        end
        if (en3)
        begin
            p3_reg   <= p3_next;
            rsq3_reg <= rsq2_reg;
        end
        if (en4)
        begin
            cl4_reg  <= cl4_next;
            ad4_reg  <= ad4_next;
            rsq4_reg <= rsq3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign cl        = cl4_reg;
    assign adist     = ad4_reg;
    assign rsq       = rsq4_reg;

endmodule

FILE: rtl/sobc_resolve.sv
// Back pipeline: distance squares, back-rotation, face pick, output register.
// Depends on sobc_pkg.
module sobc_resolve (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  sobc_pkg::vec_t    cl,
    input  sobc_pkg::adist_t  adist [3],
    input  sobc_pkg::rsq_t    rsq,
    input  sobc_pkg::vec_t    center,
    input  sobc_pkg::mat_t    mat,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              hit,
    output sobc_pkg::vec_t    contact,
    output sobc_pkg::ent_t    normal [3]
);

    logic v5_reg, v6_reg;
    logic en5, en6;

    logic [2*sobc_pkg::CW+1:0] sq5_reg [3];
    sobc_pkg::prod_t           cp5_reg [3][3];
    sobc_pkg::prod_t           cp5_next [3][3];
    sobc_pkg::rsq_t            rsq5_reg;
    logic [1:0]                axis5_reg, axis5_next;
    logic [2:0]                pos5_reg;

    logic                      hit6_reg, hit6_next;
    sobc_pkg::vec_t            ct6_reg, ct6_next;
    sobc_pkg::ent_t            nm6_reg [3];
    sobc_pkg::ent_t            nm6_next [3];

    assign en6      = !v6_reg || out_ready;
    assign en5      = !v5_reg || en6;
    assign in_ready = en5;

    // contact_i = sum_j R[i][j] * cl_j
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                cp5_next[i][j] = mat[i][j] * cl[j];
            end
        end
    end

    // largest |cl| wins; on a tie keep the earlier axis, and the minus face at zero
    always_comb
    begin
        logic [sobc_pkg::CW-1:0] a [3];
        logic [sobc_pkg::CW-1:0] best;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = cl[i][sobc_pkg::CW-1] ? sobc_pkg::CW'(-cl[i]) : sobc_pkg::CW'(cl[i]);
        end
        axis5_next = 2'd0;
        best       = a[0];
        if (a[1] > best)
        begin
            axis5_next = 2'd1;
            best       = a[1];
        end
        if (a[2] > best)
        begin
            axis5_next = 2'd2;
        end
    end

    always_comb
    begin
        logic [2*sobc_pkg::CW+3:0] dsq;
        logic signed [63:0]        s;
        dsq = (2*sobc_pkg::CW+4)'(sq5_reg[0]) + (2*sobc_pkg::CW+4)'(sq5_reg[1])
            + (2*sobc_pkg::CW+4)'(sq5_reg[2]);
        hit6_next = dsq <= (2*sobc_pkg::CW+4)'(rsq5_reg);
        for (int i = 0; i < 3; i++)
        begin
            s = 64'(cp5_reg[i][0]) + 64'(cp5_reg[i][1]) + 64'(cp5_reg[i][2]);
            ct6_next[i] = sobc_pkg::sat_coord(sobc_pkg::round14(s) + 64'(center[i]));
            nm6_next[i] = pos5_reg[axis5_reg] ? mat[i][axis5_reg] : -mat[i][axis5_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en5) v5_reg <= in_valid;
            if (en6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq5_reg[i]  <= adist[i] * adist[i];
                pos5_reg[i] <= !cl[i][sobc_pkg::CW-1] && (cl[i] != '0);
            end
            cp5_reg   <= cp5_next;
            rsq5_reg  <= rsq;
            axis5_reg <= axis5_next;
        end
        if (en6)
        begin
            hit6_reg <= hit6_next;
            ct6_reg  <= ct6_next;
            nm6_reg  <= nm6_next;
        end
    end

    assign out_valid = v6_reg;
    assign hit       = hit6_reg;
    assign contact   = ct6_reg;
    assign normal    = nm6_reg;

endmodule

FILE: rtl/sphere_oriented_box_collision.sv
// Top level of the sphere against oriented cube closest-point test.
// Depends on sobc_pkg, sobc_rot, sobc_local and sobc_resolve.
//
//  channel  signals                         word
//  -------  ------------------------------  ---------------------------------------------
//  in       s_tvalid s_tready s_tdata[127:0]  ball_x, ball_y, ball_z, ball_radius
//  out      m_tvalid m_tready m_tdata[151:0]  hit, contact_x/y/z, face_normal_x/y/z
//  config   cfg_we cfg_index cfg_wdata        register write, no read-back
//
// One word is taken every cycle while the output is not stalled; each word passes
// through the six register stages (offset, radius square, transform products,
// clamp, squares and back-rotation, output register) before it leaves.
// A stall at the output backs up stage by stage; empty stages still fill, so
// no word is dropped or repeated.
// Reset clears the valid bits and loads the register reset values; the
// rotation matrix follows a quaternion write through the product and matrix registers.
module sphere_oriented_box_collision (
    input  logic          clk,
    input  logic          rst_n,
    // ball_x[31:0], ball_y[63:32], ball_z[95:64], ball_radius[126:96], zero[127]
    input  logic [127:0]  s_tdata,
    input  logic          s_tvalid,
    output logic          s_tready,
    // hit[0], contact_x[32:1], contact_y[64:33], contact_z[96:65],
    // face_normal_x[112:97], face_normal_y[128:113], face_normal_z[144:129], zero[151:145]
    output logic [151:0]  m_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  logic          cfg_we,
    input  logic [3:0]    cfg_index,
    input  logic [31:0]   cfg_wdata
);

    sobc_pkg::vec_t   center_reg;
    sobc_pkg::ent_t   qw_reg, qx_reg, qy_reg, qz_reg;
    sobc_pkg::ulen_t  edge_reg;
    sobc_pkg::ulen_t  half;
    sobc_pkg::mat_t   mat;

    sobc_pkg::vec_t   ball;
    sobc_pkg::ulen_t  radius;

    logic             mid_valid, mid_ready;
    sobc_pkg::vec_t   mid_cl;
    sobc_pkg::adist_t mid_adist [3];
    sobc_pkg::rsq_t   mid_rsq;

    logic             hit;
    sobc_pkg::vec_t   contact;
    sobc_pkg::ent_t   normal [3];

    // register writes; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            qw_reg     <= sobc_pkg::ent_t'(sobc_pkg::ENT_MAX);
            qx_reg     <= '0;
            qy_reg     <= '0;
            qz_reg     <= '0;
            edge_reg   <= sobc_pkg::ulen_t'(65536);
        end
        else if (cfg_we)
        begin
            unique case (sobc_pkg::reg_idx_t'(cfg_index))
                sobc_pkg::REG_CX:   center_reg[0] <= cfg_wdata;
                sobc_pkg::REG_CY:   center_reg[1] <= cfg_wdata;
                sobc_pkg::REG_CZ:   center_reg[2] <= cfg_wdata;
                sobc_pkg::REG_QW:   qw_reg        <= cfg_wdata[15:0];
                sobc_pkg::REG_QX:   qx_reg        <= cfg_wdata[15:0];
                sobc_pkg::REG_QY:   qy_reg        <= cfg_wdata[15:0];
                sobc_pkg::REG_QZ:   qz_reg        <= cfg_wdata[15:0];
                sobc_pkg::REG_EDGE: edge_reg      <= cfg_wdata[30:0];
                default:            ;
            endcase
        end
    end

    // half the edge, floored
    assign half = edge_reg >> 1;

    // unpack the input word
    assign ball[0] = s_tdata[31:0];
    assign ball[1] = s_tdata[63:32];
    assign ball[2] = s_tdata[95:64];
    assign radius  = s_tdata[126:96];

    sobc_rot u_rot (
        .clk (clk),
        .qw  (qw_reg),
        .qx  (qx_reg),
        .qy  (qy_reg),
        .qz  (qz_reg),
        .mat (mat)
    );

    sobc_local u_local (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .ball      (ball),
        .radius    (radius),
        .center    (center_reg),
        .mat       (mat),
        .half      (half),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .cl        (mid_cl),
        .adist     (mid_adist),
        .rsq       (mid_rsq)
    );

    sobc_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .cl        (mid_cl),
        .adist     (mid_adist),
        .rsq       (mid_rsq),
        .center    (center_reg),
        .mat       (mat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .hit       (hit),
        .contact   (contact),
        .normal    (normal)
    );

    // pack the result word
    assign m_tdata = {7'd0, normal[2], normal[1], normal[0],
                      contact[2], contact[1], contact[0], hit};

`ifndef SYNTHESIS
    // input only backs up when every stage is full behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while output side could move");

    // a face normal component never exceeds one in magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((normal[0] <= 16'sd16384) && (normal[0] >= -16'sd16384)
                   && (normal[1] <= 16'sd16384) && (normal[1] >= -16'sd16384)
                   && (normal[2] <= 16'sd16384) && (normal[2] >= -16'sd16384)))
        else $error("face normal component out of range");

    // no word is shown while reset holds
    assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("output valid during reset");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the sphere against oriented cube closest-point block.
// Depends on sobc_pkg and sphere_oriented_box_collision; drives streams and config port.
`timescale 1ns / 1ps

module testbench;

    // one input word and one output word, as unpacked fields
    typedef struct {
        logic signed [31:0] bx, by, bz;
        logic [30:0]        rad;
    } ball_t;

    typedef struct {
        logic               hit;
        logic signed [31:0] px, py, pz;
        logic signed [15:0] nx, ny, nz;
    } contact_t;

    // directed row: ball plus an optional typed-in expectation
    typedef struct {
        ball_t    b;
        logic     known;
        contact_t exp_c;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic [127:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [151:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_we;
    logic [3:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    // shadow copy of the cube registers
    logic signed [31:0] cube_c [3];
    logic signed [15:0] quat [4];   // w, x, y, z
    logic [30:0]        cube_edge;

    contact_t contacts_due [$];
    int  mismatches;
    int  words_sent;
    int  words_seen;
    int  hits_seen;
    bit  hold_off;

    sphere_oriented_box_collision uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // generous overall limit
    initial
    begin
        #50ms;
        $display("Timeout with %0d words still due", contacts_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint fsat(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // add half, floor shift by 14
    function automatic longint rnd14(longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic longint clamp_ent(longint v);
        longint r;
        r = rnd14(v);
        return r > 16384 ? 16384 : (r < -16384 ? -16384 : r);
    endfunction

    // compute the expected contact for one ball against the current cube
    function automatic contact_t closest_point(ball_t b);
        contact_t res;
        longint w, x, y, z, one, half, s, offs, best, n;
        longint m [3][3];
        longint c [3];
        longint d [3];
        longint loc [3];
        longint cl [3];
        longint bv [3];
        logic [127:0] dsq, rsq, df;
        longint px [3];
        int face, axis;
        w = quat[0]; x = quat[1]; y = quat[2]; z = quat[3];
        one = 64'sd1 << 28;
        half = longint'(cube_edge) / 2;
        m[0][0] = clamp_ent(one - 2 * (y * y + z * z));
        m[0][1] = clamp_ent(2 * (x * y - w * z));
        m[0][2] = clamp_ent(2 * (x * z + w * y));
        m[1][0] = clamp_ent(2 * (x * y + w * z));
        m[1][1] = clamp_ent(one - 2 * (x * x + z * z));
        m[1][2] = clamp_ent(2 * (y * z - w * x));
        m[2][0] = clamp_ent(2 * (x * z - w * y));
        m[2][1] = clamp_ent(2 * (y * z + w * x));
        m[2][2] = clamp_ent(one - 2 * (x * x + y * y));
        bv[0] = b.bx; bv[1] = b.by; bv[2] = b.bz;
        dsq = '0;
        for (int i = 0; i < 3; i++)
        begin
            c[i] = cube_c[i];
            d[i] = fsat(bv[i] - c[i]);
        end
        for (int i = 0; i < 3; i++)
        begin
            s = 0;
            for (int j = 0; j < 3; j++)
                s += m[j][i] * d[j];
            loc[i] = fsat(rnd14(s));
            cl[i] = loc[i] > half ? half : (loc[i] < -half ? -half : loc[i]);
            offs = loc[i] - cl[i];
            df = 128'(offs < 0 ? -offs : offs);
            dsq += df * df;
        end
        rsq = 128'(b.rad) * 128'(b.rad);
        res.hit = (dsq <= rsq);
        for (int i = 0; i < 3; i++)
        begin
            s = 0;
            for (int j = 0; j < 3; j++)
                s += m[i][j] * cl[j];
            px[i] = fsat(rnd14(s) + c[i]);
        end
        res.px = 32'(px[0]); res.py = 32'(px[1]); res.pz = 32'(px[2]);
        // face order -x +x -y +y -z +z, ties to the earlier one
        face = 0;
        best = -cl[0];
        for (int i = 1; i < 6; i++)
        begin
            offs = (i & 1) ? cl[i >> 1] : -cl[i >> 1];
            if (offs > best)
            begin
                best = offs;
                face = i;
            end
        end
        axis = face >> 1;
        n = (face & 1) ? m[0][axis] : -m[0][axis];
        res.nx = 16'(n);
        n = (face & 1) ? m[1][axis] : -m[1][axis];
        res.ny = 16'(n);
        n = (face & 1) ? m[2][axis] : -m[2][axis];
        res.nz = 16'(n);
        return res;
    endfunction

    // mostly short gaps, now and then a long one, often none
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // drive one register write; the caller drops the write enable afterwards
    task automatic write_reg(sobc_pkg::reg_idx_t idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            sobc_pkg::REG_CX:   cube_c[0] = val;
            sobc_pkg::REG_CY:   cube_c[1] = val;
            sobc_pkg::REG_CZ:   cube_c[2] = val;
            sobc_pkg::REG_QW:   quat[0] = val[15:0];
            sobc_pkg::REG_QX:   quat[1] = val[15:0];
            sobc_pkg::REG_QY:   quat[2] = val[15:0];
            sobc_pkg::REG_QZ:   quat[3] = val[15:0];
            sobc_pkg::REG_EDGE: cube_edge = val[30:0];
            default: ;
        endcase
    endtask

    task automatic load_cube(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                             logic [15:0] qw, logic [15:0] qx, logic [15:0] qy,
                             logic [15:0] qz, logic [30:0] e);
        write_reg(sobc_pkg::REG_CX, cx);
        write_reg(sobc_pkg::REG_CY, cy);
        write_reg(sobc_pkg::REG_CZ, cz);
        write_reg(sobc_pkg::REG_QW, {{16{qw[15]}}, qw});
        write_reg(sobc_pkg::REG_QX, {{16{qx[15]}}, qx});
        write_reg(sobc_pkg::REG_QY, {{16{qy[15]}}, qy});
        write_reg(sobc_pkg::REG_QZ, {{16{qz[15]}}, qz});
        write_reg(sobc_pkg::REG_EDGE, {1'b0, e});
        cfg_we <= 1'b0;
        // let the matrix settle after the quaternion writes
        repeat (4) @(posedge clk);
    endtask

    // offer one word and hold it until taken
    task automatic send_ball(ball_t b, contact_t want);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        s_tdata  <= {1'b0, b.rad, b.bz, b.by, b.bx};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        contacts_due = {contacts_due, want};
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (contacts_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    function automatic ball_t rand_ball(int spread);
        ball_t b;
        int p;
        p = $urandom_range(0, 19);
        if (p == 0)
        begin
            // full-range noise reaches every bit and the saturation paths
            b.bx = $urandom; b.by = $urandom; b.bz = $urandom;
            b.rad = 31'($urandom);
        end
        else
        begin
            b.bx = cube_c[0] + $signed($urandom_range(0, 2 * spread)) - spread;
            b.by = cube_c[1] + $signed($urandom_range(0, 2 * spread)) - spread;
            b.bz = cube_c[2] + $signed($urandom_range(0, 2 * spread)) - spread;
            b.rad = 31'($urandom_range(0, spread));
        end
        return b;
    endfunction

    // unit quaternions from a short list, or four random components off unit length
    task automatic random_cube(bit extreme);
        logic [15:0] q [4];
        int k;
        k = $urandom_range(0, 5);
        case (k)
            0: begin q[0] = 16'sd16384; q[1] = 16'sd0; q[2] = 16'sd0; q[3] = 16'sd0; end
            1: begin q[0] = 16'sd11585; q[1] = 16'sd0; q[2] = 16'sd0; q[3] = 16'sd11585; end
            2: begin q[0] = 16'sd8192; q[1] = 16'sd8192; q[2] = 16'sd8192; q[3] = 16'sd8192; end
            3: begin q[0] = 16'sd15137; q[1] = 16'sd6270; q[2] = 16'sd0; q[3] = 16'sd0; end
            4: begin q[0] = -16'sd9459; q[1] = 16'sd9459; q[2] = -16'sd9459; q[3] = 16'sd0; end
            default:
            begin
                for (int i = 0; i < 4; i++)
                    q[i] = 16'($urandom_range(0, 32768) - 16384);
            end
        endcase
        if (extreme)
            load_cube($urandom, $urandom, $urandom, q[0], q[1], q[2], q[3],
                      31'($urandom));
        else
            load_cube($urandom_range(0, 2000000) - 1000000,
                      $urandom_range(0, 2000000) - 1000000,
                      $urandom_range(0, 2000000) - 1000000,
                      q[0], q[1], q[2], q[3], 31'($urandom_range(0, 400000)));
    endtask

    // output side: random back-pressure plus one long hold-off
    initial
    begin
        int g;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            g = gap_len();
            if (g > 0 && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // compare each delivered word with the oldest expectation
    always @(posedge clk)
    begin
        contact_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.hit = m_tdata[0];
            got.px  = m_tdata[32:1];
            got.py  = m_tdata[64:33];
            got.pz  = m_tdata[96:65];
            got.nx  = m_tdata[112:97];
            got.ny  = m_tdata[128:113];
            got.nz  = m_tdata[144:129];
            words_seen++;
            hits_seen += got.hit;
            if (contacts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected word at %0t: %p", $realtime, got);
            end
            else
            begin
                want = contacts_due.pop_front();
                if (got.hit !== want.hit || got.px !== want.px || got.py !== want.py
                    || got.pz !== want.pz || got.nx !== want.nx
                    || got.ny !== want.ny || got.nz !== want.nz)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch on word %0d: expected %p, got %p",
                                 words_seen, want, got);
                end
            end
        end
    end

    initial
    begin
        row_t   rows [$];
        row_t   r;
        ball_t  b;
        int     n;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_we     = 1'b0;
        cfg_index  = sobc_pkg::REG_CX;
        cfg_wdata  = '0;
        mismatches = 0;
        words_sent = 0;
        words_seen = 0;
        hits_seen  = 0;
        hold_off   = 1'b0;
        // register reset values: identity rotation, unit edge at the origin
        cube_c[0] = 0; cube_c[1] = 0; cube_c[2] = 0;
        quat[0] = 16384; quat[1] = 0; quat[2] = 0; quat[3] = 0;
        cube_edge = 65536;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows against the reset cube; known answers typed in
        r.known = 1'b1;
        // centre inside: distance zero, tie goes to the -x face
        r.b = '{0, 0, 0, 0};
        r.exp_c = '{1'b1, 0, 0, 0, -16384, 0, 0};
        rows = {rows, r};
        // far out along +x: clamp to half edge, +x face, no hit
        r.b = '{32'sh00100000, 0, 0, 31'd0};
        r.exp_c = '{1'b0, 32'sh8000, 0, 0, 16384, 0, 0};
        rows = {rows, r};
        // same contact point, ball at 1.5 on x, radius exactly reaching the face
        r.b = '{32'sh00018000, 0, 0, 31'h10000};
        r.exp_c = '{1'b1, 32'sh8000, 0, 0, 16384, 0, 0};
        rows = {rows, r};
        // far along -z with the largest radius
        r.b = '{0, 0, -32'sh00200000, 31'h7fffffff};
        r.exp_c = '{1'b1, 0, 0, -32'sh8000, 0, 0, -16384};
        rows = {rows, r};
        // extremes of every coordinate and one ball just past the +y face, checked by the predictor
        r.known = 1'b0;
        r.b = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 31'h7fffffff};
        rows = {rows, r};
        r.b = '{32'h80000000, 32'h80000000, 32'h80000000, 31'd0};
        rows = {rows, r};
        r.b = '{32'h80000000, 32'h7fffffff, 0, 31'h12345};
        rows = {rows, r};
        r.b = '{0, 32'sh00009000, 32'sh00000100, 31'd1};
        rows = {rows, r};
        foreach (rows[i])
            send_ball(rows[i].b, rows[i].known ? rows[i].exp_c : closest_point(rows[i].b));
        drain();

        // rotated cube far off-centre, non-unit quaternion, then zero edge
        load_cube(32'h7fff0000, 32'h80010000, 32'h00010000, 16'sd11585, 16'sd0,
                  16'sd11585, 16'sd0, 31'h20000);
        for (int i = 0; i < 6; i++)
        begin
            b = rand_ball(200000);
            send_ball(b, closest_point(b));
        end
        drain();
        load_cube(0, 0, 0, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 31'h7fffffff);
        for (int i = 0; i < 4; i++)
        begin
            b = rand_ball(100000);
            send_ball(b, closest_point(b));
        end
        drain();
        load_cube(32'h1000, 32'h2000, 32'h3000, 16'sd8192, 16'sd8192, 16'sd8192,
                  16'sd8192, 31'd0);
        for (int i = 0; i < 4; i++)
        begin
            b = rand_ball(100000);
            send_ball(b, closest_point(b));
        end
        drain();

        // random phases, each with a fresh cube
        for (int ph = 0; ph < 26; ph++)
        begin
            random_cube(ph % 8 == 7);
            if (ph == 5)
                hold_off = 1'b1;    // sender keeps offering while output holds off
            n = 50;
            for (int i = 0; i < n; i++)
            begin
                b = rand_ball($urandom_range(0, 3) == 0 ? 2000000 : 300000);
                send_ball(b, closest_point(b));
            end
            drain();
        end

        $display("Sent %0d spheres over 30 cube settings; %0d results, %0d hits.",
                 words_sent, words_seen, hits_seen);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatches in total", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
